>>> hdl/oriented_box_wireframe_edges_defines.svh
// -----------------------------------------------------------------------------
// Oriented box wireframe edges: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// -----------------------------------------------------------------------------
`ifndef ORIENTED_BOX_WIREFRAME_EDGES_DEFINES_SVH
`define ORIENTED_BOX_WIREFRAME_EDGES_DEFINES_SVH

// Same-cycle implication.
`define OBWE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OBWE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/obwe_pkg.sv
// -----------------------------------------------------------------------------
// obwe_pkg
// Types, widths and edge tables shared by the box wireframe edge generator.
// -----------------------------------------------------------------------------
package obwe_pkg;

  localparam int NCORNER = 8;
  localparam int NEDGE   = 12;
  localparam int CIW     = 3;   // corner index bits
  localparam int EIW     = 4;   // edge index bits
  localparam int NSLOT   = 2;   // queue depth and corner banks
  localparam int SLW     = 1;
  localparam int RAW     = SLW + CIW;

  // arithmetic widths
  localparam int PW  = 33;  // local corner component (+-half, exact)
  localparam int MW  = 49;  // q * p
  localparam int DW  = 50;  // difference of two q * p
  localparam int TW  = 37;  // t component
  localparam int M2W = 53;  // q * t
  localparam int XW  = 54;  // difference of two q * t
  localparam int RW  = 42;  // centre + rotated corner

  localparam int IN_DW  = 288;
  localparam int OUT_DW = 224;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_EOF  = 1'b1;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } obwe_pt_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] color;
  } obwe_box_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [SLW-1:0] wr_slot;
    logic [SLW-1:0] rd_slot;
  } obwe_qstat_t;

  function automatic logic [CIW-1:0] edge_a(input logic [EIW-1:0] e);
    logic [CIW-1:0] c;
    unique case (e)
      4'd0:    c = 3'd0;
      4'd1:    c = 3'd1;
      4'd2:    c = 3'd2;
      4'd3:    c = 3'd3;
      4'd4:    c = 3'd4;
      4'd5:    c = 3'd5;
      4'd6:    c = 3'd6;
      4'd7:    c = 3'd7;
      4'd8:    c = 3'd0;
      4'd9:    c = 3'd1;
      4'd10:   c = 3'd2;
      4'd11:   c = 3'd3;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [CIW-1:0] edge_b(input logic [EIW-1:0] e);
    logic [CIW-1:0] c;
    unique case (e)
      4'd0:    c = 3'd1;
      4'd1:    c = 3'd2;
      4'd2:    c = 3'd3;
      4'd3:    c = 3'd0;
      4'd4:    c = 3'd5;
      4'd5:    c = 3'd6;
      4'd6:    c = 3'd7;
      4'd7:    c = 3'd4;
      4'd8:    c = 3'd4;
      4'd9:    c = 3'd5;
      4'd10:   c = 3'd6;
      4'd11:   c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [RW-1:0] v);
    logic signed [31:0] r;
    if ((&v[RW-1:31]) || !(|v[RW-1:31])) begin
      r = v[31:0];
    end else if (v[RW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

>>> hdl/oriented_box_wireframe_edges.sv
// -----------------------------------------------------------------------------
// oriented_box_wireframe_edges
// Oriented box to twelve wireframe edges, with a per-frame vertex budget.
// -----------------------------------------------------------------------------
// Input stream s_axis: one item per box (tuser = 0) or end of frame (tuser = 1).
// Output stream m_axis: one item per emitted edge, tlast on the box's last
// emitted edge; a box whose budget is spent yields no item at all.
// Configuration: cfg_we_i writes max_vertices from cfg_wdata_i; write only
// while the block is idle.
// A box's first edge follows once its eight corners have passed the rotate
// pipeline into the corner RAM and its first corner pair has been read.
// The back walks the edges at one edge per cycle while the receiver takes
// them. A two-entry queue with two corner banks lets the front rotate the
// next box while the back emits the current one.
// End-of-frame items pass the queue in order and clear the line count.
// Reset empties the queue, clears the line count, sets max_vertices to 65535.
// s_axis_tready stays low while the front rotates a box. When the receiver
// stalls, the output register holds its item, the back stops reading, and
// once both banks are full s_axis_tready stays low until the back pops.
// -----------------------------------------------------------------------------
`include "oriented_box_wireframe_edges_defines.svh"

module oriented_box_wireframe_edges (
  input  logic         clk_i,
  input  logic         rst_ni,
  // fields from bit 0: center_x, center_y, center_z, half_x, half_y, half_z,
  // quat_x, quat_y, quat_z, quat_w, line_color
  input  logic [287:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,   // cmd
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // fields from bit 0: start_x, start_y, start_z, end_x, end_y, end_z,
  // edge_color
  output logic [223:0] m_axis_tdata,
  output logic         m_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);
  import obwe_pkg::*;

  obwe_qstat_t    qstat;
  obwe_box_t      push_box, head;
  logic           push, pop;
  logic           ram_we, ram_re;
  logic [RAW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  obwe_pt_t       ram_wdata, ram_rdata_a, ram_rdata_b;

  obwe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_cmd_i     (s_axis_tuser[0]),
    .s_data_i    (s_axis_tdata),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_box_o  (push_box),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  obwe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_box_i (push_box),
    .pop_i      (pop),
    .head_o     (head),
    .qstat_o    (qstat)
  );

  obwe_ram #(
    .WIDTH ($bits(obwe_pt_t)),
    .DEPTH (NSLOT * NCORNER)
  ) u_corner_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  obwe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .head_i        (head),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .ram_re_o      (ram_re),
    .ram_raddr_a_o (ram_raddr_a),
    .ram_raddr_b_o (ram_raddr_b),
    .ram_rdata_a_i (ram_rdata_a),
    .ram_rdata_b_i (ram_rdata_b),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_o      (m_axis_tdata),
    .m_last_o      (m_axis_tlast)
  );

  `OBWE_ASSERT_NOW(a_no_push_full, push && !pop, !qstat.full, "push into full queue")
  `OBWE_ASSERT_NOW(a_no_pop_empty, pop, !qstat.empty, "pop from empty queue")
  `OBWE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed while stalled")
  `OBWE_ASSERT_NOW(a_read_not_written, ram_re && ram_we, ram_raddr_a[RAW-1] != ram_waddr[RAW-1], "corner bank read while written")

endmodule

>>> hdl/obwe_ram.sv
// -----------------------------------------------------------------------------
// obwe_ram
// Generic RAM: one write port, two read ports with registered read data.
// -----------------------------------------------------------------------------
module obwe_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> hdl/obwe_front.sv
// -----------------------------------------------------------------------------
// obwe_front
// Accepts items, passes end-frame commands on and runs the eight corners of a
// box through the rotate pipeline into the corner RAM.
// -----------------------------------------------------------------------------
module obwe_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic                         s_cmd_i,
  input  logic [obwe_pkg::IN_DW-1:0]   s_data_i,
  input  obwe_pkg::obwe_qstat_t        qstat_i,
  output logic                         push_o,
  output obwe_pkg::obwe_box_t          push_box_o,
  output logic                         ram_we_o,
  output logic [obwe_pkg::RAW-1:0]     ram_waddr_o,
  output obwe_pkg::obwe_pt_t           ram_wdata_o
);
  import obwe_pkg::*;

  logic accept;
  logic busy_q, busy_d;
  logic [CIW:0] kidx_q, kidx_d;
  logic issue;

  logic signed [31:0] cx_q, cy_q, cz_q, hx_q, hy_q, hz_q;
  logic signed [15:0] qx_q, qy_q, qz_q, qw_q;
  logic [31:0] color_q;

  // stage 1: local corner and q x p products
  logic                  v1_q;
  logic [CIW-1:0]        i1_q;
  logic signed [PW-1:0]  p1x_q, p1y_q, p1z_q;
  logic signed [MW-1:0]  m1_q [6];
  // stage 2: t vector
  logic                  v2_q;
  logic [CIW-1:0]        i2_q;
  logic signed [PW-1:0]  p2x_q, p2y_q, p2z_q;
  logic signed [TW-1:0]  t2x_q, t2y_q, t2z_q;
  // stage 3: q x t products
  logic                  v3_q;
  logic [CIW-1:0]        i3_q;
  logic signed [PW-1:0]  p3x_q, p3y_q, p3z_q;
  logic signed [M2W-1:0] a3x_q, a3y_q, a3z_q;
  logic signed [M2W-1:0] b3_q [6];

  logic [CIW-1:0]       kc, kp1;
  logic signed [PW-1:0] px, py, pz;
  logic signed [DW-1:0] dx, dy, dz;
  logic signed [XW-1:0] ex, ey, ez;
  logic signed [RW-1:0] rx, ry, rz;
  logic                 done;

  assign s_ready_o = !busy_q && !qstat_i.full;
  assign accept    = s_valid_i && s_ready_o;
  assign issue     = busy_q && !kidx_q[CIW];

  // corner selection: x follows bit 1 of i+1, y bit 1, z bit 2
  always_comb begin
    kc  = kidx_q[CIW-1:0];
    kp1 = kc + 3'd1;
    px  = kp1[1] ? PW'(hx_q) : -PW'(hx_q);
    py  = kc[1]  ? PW'(hy_q) : -PW'(hy_q);
    pz  = kc[2]  ? PW'(hz_q) : -PW'(hz_q);
  end

  always_comb begin
    dx = DW'(m1_q[0]) - DW'(m1_q[1]);
    dy = DW'(m1_q[2]) - DW'(m1_q[3]);
    dz = DW'(m1_q[4]) - DW'(m1_q[5]);
    ex = XW'(b3_q[0]) - XW'(b3_q[1]);
    ey = XW'(b3_q[2]) - XW'(b3_q[3]);
    ez = XW'(b3_q[4]) - XW'(b3_q[5]);
    rx = RW'(cx_q) + RW'(p3x_q) + RW'(a3x_q >>> 14) + RW'(ex >>> 14);
    ry = RW'(cy_q) + RW'(p3y_q) + RW'(a3y_q >>> 14) + RW'(ey >>> 14);
    rz = RW'(cz_q) + RW'(p3z_q) + RW'(a3z_q >>> 14) + RW'(ez >>> 14);
  end

  assign done = v3_q && (i3_q == CIW'(NCORNER - 1));

  assign ram_we_o      = v3_q;
  assign ram_waddr_o   = {qstat_i.wr_slot, i3_q};
  assign ram_wdata_o.x = sat32(rx);
  assign ram_wdata_o.y = sat32(ry);
  assign ram_wdata_o.z = sat32(rz);

  // end-frame goes straight to the queue; a box goes once its last corner lands
  assign push_o           = (accept && (s_cmd_i == CMD_EOF)) || done;
  assign push_box_o.cmd   = done ? CMD_DRAW : CMD_EOF;
  assign push_box_o.color = color_q;

  always_comb begin
    busy_d = busy_q;
    kidx_d = kidx_q;
    if (accept && (s_cmd_i == CMD_DRAW)) begin
      busy_d = 1'b1;
      kidx_d = '0;
    end else begin
      if (issue) begin
        kidx_d = kidx_q + 4'd1;
      end
      if (done) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kidx_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      kidx_q <= kidx_d;
      v1_q   <= issue;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q    <= s_data_i[31:0];
      cy_q    <= s_data_i[63:32];
      cz_q    <= s_data_i[95:64];
      hx_q    <= s_data_i[127:96];
      hy_q    <= s_data_i[159:128];
      hz_q    <= s_data_i[191:160];
      qx_q    <= s_data_i[207:192];
      qy_q    <= s_data_i[223:208];
      qz_q    <= s_data_i[239:224];
      qw_q    <= s_data_i[255:240];
      color_q <= s_data_i[287:256];
    end
    // stage 1
    i1_q    <= kc;
    p1x_q   <= px;
    p1y_q   <= py;
    p1z_q   <= pz;
    m1_q[0] <= MW'(qy_q) * MW'(pz);
    m1_q[1] <= MW'(qz_q) * MW'(py);
    m1_q[2] <= MW'(qz_q) * MW'(px);
    m1_q[3] <= MW'(qx_q) * MW'(pz);
    m1_q[4] <= MW'(qx_q) * MW'(py);
    m1_q[5] <= MW'(qy_q) * MW'(px);
    // stage 2: (2*d) >> 14 is d >> 13
    i2_q  <= i1_q;
    p2x_q <= p1x_q;
    p2y_q <= p1y_q;
    p2z_q <= p1z_q;
    t2x_q <= TW'(dx >>> 13);
    t2y_q <= TW'(dy >>> 13);
    t2z_q <= TW'(dz >>> 13);
    // stage 3
    i3_q    <= i2_q;
    p3x_q   <= p2x_q;
    p3y_q   <= p2y_q;
    p3z_q   <= p2z_q;
    a3x_q   <= M2W'(qw_q) * M2W'(t2x_q);
    a3y_q   <= M2W'(qw_q) * M2W'(t2y_q);
    a3z_q   <= M2W'(qw_q) * M2W'(t2z_q);
    b3_q[0] <= M2W'(qy_q) * M2W'(t2z_q);
    b3_q[1] <= M2W'(qz_q) * M2W'(t2y_q);
    b3_q[2] <= M2W'(qz_q) * M2W'(t2x_q);
    b3_q[3] <= M2W'(qx_q) * M2W'(t2z_q);
    b3_q[4] <= M2W'(qx_q) * M2W'(t2y_q);
    b3_q[5] <= M2W'(qy_q) * M2W'(t2x_q);
  end

endmodule

>>> hdl/obwe_queue.sv
// -----------------------------------------------------------------------------
// obwe_queue
// Two-entry queue of box descriptors; the slot index also names the corner
// bank that the entry owns.
// -----------------------------------------------------------------------------
module obwe_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  obwe_pkg::obwe_box_t   push_box_i,
  input  logic                  pop_i,
  output obwe_pkg::obwe_box_t   head_o,
  output obwe_pkg::obwe_qstat_t qstat_o
);
  import obwe_pkg::*;

  obwe_box_t       ent_q [NSLOT];
  logic [SLW-1:0]  wr_q, rd_q;
  logic [SLW:0]    cnt_q;

  assign head_o          = ent_q[rd_q];
  assign qstat_o.full    = (cnt_q == (SLW+1)'(NSLOT));
  assign qstat_o.empty   = (cnt_q == '0);
  assign qstat_o.wr_slot = wr_q;
  assign qstat_o.rd_slot = rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_box_i;
    end
  end

endmodule

>>> hdl/obwe_back.sv
// -----------------------------------------------------------------------------
// obwe_back
// Walks the edges of the head box, reads both corners from the corner RAM,
// applies the frame budget and drives the output register.
// -----------------------------------------------------------------------------
module obwe_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [15:0]                   cfg_wdata_i,
  input  obwe_pkg::obwe_box_t           head_i,
  input  obwe_pkg::obwe_qstat_t         qstat_i,
  output logic                          pop_o,
  output logic                          ram_re_o,
  output logic [obwe_pkg::RAW-1:0]      ram_raddr_a_o,
  output logic [obwe_pkg::RAW-1:0]      ram_raddr_b_o,
  input  obwe_pkg::obwe_pt_t            ram_rdata_a_i,
  input  obwe_pkg::obwe_pt_t            ram_rdata_b_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [obwe_pkg::OUT_DW-1:0]   m_data_o,
  output logic                          m_last_o
);
  import obwe_pkg::*;

  logic [15:0]    max_q;
  logic [15:0]    cnt_q, cnt_d;
  logic [EIW-1:0] issue_e_q, issue_e_d;
  logic [EIW-1:0] pend_e_q;
  logic           pend_q, pend_d;
  logic           out_valid_q, out_valid_d;
  logic           out_last_q;
  obwe_pt_t       out_a_q, out_b_q;
  logic [31:0]    out_color_q;

  logic has_box, eof_pop, load, exhausted, last_flag, finish, emit, issue;
  logic [16:0] cnt_inc;

  assign has_box   = !qstat_i.empty && (head_i.cmd == CMD_DRAW);
  assign eof_pop   = !qstat_i.empty && (head_i.cmd == CMD_EOF);
  assign load      = pend_q && (!out_valid_q || m_ready_i);
  assign cnt_inc   = {1'b0, cnt_q} + 17'd1;
  assign exhausted = {cnt_q, 1'b0} >= {1'b0, max_q};
  assign last_flag = (pend_e_q == EIW'(NEDGE - 1)) ||
                     ({cnt_inc, 1'b0} >= {2'b00, max_q});
  assign finish    = load && (exhausted || last_flag);
  assign emit      = load && !exhausted;
  assign issue     = has_box && (issue_e_q < EIW'(NEDGE)) && (!pend_q || (load && !finish));
  assign pop_o     = eof_pop || finish;

  assign ram_re_o      = issue;
  assign ram_raddr_a_o = {qstat_i.rd_slot, edge_a(issue_e_q)};
  assign ram_raddr_b_o = {qstat_i.rd_slot, edge_b(issue_e_q)};

  assign m_valid_o = out_valid_q;
  assign m_last_o  = out_last_q;
  assign m_data_o  = {out_color_q, out_b_q.z, out_b_q.y, out_b_q.x,
                      out_a_q.z, out_a_q.y, out_a_q.x};

  always_comb begin
    cnt_d       = cnt_q;
    issue_e_d   = issue_e_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (eof_pop) begin
      cnt_d = '0;
    end else if (emit) begin
      cnt_d = cnt_inc[15:0];
    end
    if (pop_o) begin
      issue_e_d = '0;
    end else if (issue) begin
      issue_e_d = issue_e_q + 4'd1;
    end
    if (issue) begin
      pend_d = 1'b1;
    end else if (load) begin
      pend_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= 16'hffff;
      cnt_q       <= '0;
      issue_e_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      cnt_q       <= cnt_d;
      issue_e_q   <= issue_e_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_e_q <= issue_e_q;
    end
    if (emit) begin
      out_a_q     <= ram_rdata_a_i;
      out_b_q     <= ram_rdata_b_i;
      out_color_q <= head_i.color;
      out_last_q  <= last_flag;
    end
  end

endmodule
